FILE: rtl/shr_pkg.sv
// package for the solid harmonics recurrence block: types, constants, helpers
package shr_pkg;

  localparam int unsigned MaxDegreeBound = 7;
  localparam int unsigned ValW = 48;
  localparam int unsigned CoordW = 32;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] OneQ46 = 48'sh4000_0000_0000;

  localparam logic AddrMaxDegree = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } shr_in_t;

  typedef struct packed {
    logic [2:0]             degree;
    logic signed [3:0]      order;
    logic signed [ValW-1:0] value;
    logic                   last;
  } shr_out_t;

  // datapath operation selects
  typedef enum logic [2:0] {
    OP_LOAD, OP_RSQ, OP_MUL, OP_ACC, OP_SCALE, OP_WRITE
  } shr_op_e;

  // controller to datapath command
  typedef struct packed {
    logic              start;     // capture point
    logic              col_init;  // set prev to diag, prev2 to 0
    logic              diag_init; // diag = (1,0)
    logic [2:0]        mul_a;     // multiplicand select
    logic [2:0]        mul_b;     // multiplier select
    logic [5:0]        shift;     // product shift
    logic              acc_clr;
    logic              acc_sub;
    logic              acc_en;
    logic              acc_wide;  // acc scaled by integer
    logic [3:0]        coef;      // 2l-1
    logic              sel_neg;   // pair half
    logic              wr_l;      // write l-step result
    logic              wr_d;      // write diagonal result
    logic              neg_res;
    logic              p_en;
  } shr_cmd_t;

  typedef struct packed {
    logic signed [ValW-1:0] result;
  } shr_stat_t;

  // round(2^32/k) for k up to 49
  function automatic logic [32:0] recip(input logic [5:0] k);
    logic [32:0] r;
    begin
      r = 33'd0;
      case (k)
        6'd1:  r = 33'h1_0000_0000;
        6'd2:  r = 33'h0_8000_0000;
        6'd3:  r = 33'h0_5555_5555;
        6'd4:  r = 33'h0_4000_0000;
        6'd5:  r = 33'h0_3333_3333;
        6'd6:  r = 33'h0_2AAA_AAAB;
        6'd7:  r = 33'h0_2492_4925;
        6'd8:  r = 33'h0_2000_0000;
        6'd9:  r = 33'h0_1C71_C71C;
        6'd10: r = 33'h0_1999_999A;
        6'd11: r = 33'h0_1745_D174;
        6'd12: r = 33'h0_1555_5555;
        6'd13: r = 33'h0_13B1_3B14;
        6'd14: r = 33'h0_1249_2492;
        6'd15: r = 33'h0_1111_1111;
        6'd16: r = 33'h0_1000_0000;
        6'd20: r = 33'h0_0CCC_CCCD;
        6'd21: r = 33'h0_0C30_C30C;
        6'd24: r = 33'h0_0AAA_AAAB;
        6'd25: r = 33'h0_0A3D_70A4;
        6'd27: r = 33'h0_097B_425F;
        6'd32: r = 33'h0_0800_0000;
        6'd33: r = 33'h0_07C1_F07C;
        6'd35: r = 33'h0_0750_7507;
        6'd36: r = 33'h0_071C_71C7;
        6'd40: r = 33'h0_0666_6666;
        6'd45: r = 33'h0_05B0_5B06;
        6'd48: r = 33'h0_0555_5555;
        6'd49: r = 33'h0_0539_782A;
        default: r = 33'd0;
      endcase
      recip = r;
    end
  endfunction

endpackage

FILE: rtl/shr_datapath.sv
// datapath: shared 32x32 multiplier, rounding shifter and accumulator
module shr_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shr_pkg::shr_in_t  point_i,
  input  logic [2:0]      l_i,
  input  logic [2:0]      m_i,
  input  logic [1:0]      step_i,
  input  logic            go_i,
  input  logic            kind_i,    // 0: l step, 1: diagonal step
  input  logic            half_i,    // 0: N+, 1: N-
  input  logic            start_i,
  input  logic            col_init_i,
  input  logic            diag_init_i,
  output logic            done_o,
  output logic signed [47:0] result_o
);
  import shr_pkg::*;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [47:0] rsq_q;
  logic signed [ValW-1:0] diag_q [2];
  logic signed [ValW-1:0] prev_q [2];
  logic signed [ValW-1:0] prev2_q [2];
  logic signed [52:0] acc_q;

  // sign-magnitude multiply with rounding shift, ties away from zero
  logic [63:0] ma, mb;
  logic        neg;
  logic [5:0]  sh;
  logic [127:0] rnd;
  logic signed [66:0] term;

  // partial product sequencing
  logic [2:0]   ph_q;
  logic [127:0] prod_q, prod_d;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;

  logic signed [ValW-1:0] opa;
  logic signed [63:0] opb;
  logic [5:0] kden;
  logic [3:0] lsum;
  logic [2:0] ldif;
  logic [3:0] coef;

  always_comb begin
    lsum = {1'b0, l_i} + {1'b0, m_i};
    ldif = l_i - m_i;
    kden = {2'b00, lsum} * {3'b000, ldif};
    coef = 4'({l_i, 1'b0} - 4'd1);
    opa = 48'sd0;
    opb = 64'sd0;
    sh = 6'd30;
    if (kind_i == 1'b0) begin
      case (step_i)
        2'd0: begin opa = prev_q[half_i]; opb = 64'(cz_q); sh = 6'd30; end
        2'd1: begin opa = prev2_q[half_i]; opb = $signed({16'd0, rsq_q}); sh = 6'd46; end
        default: begin opa = 48'sd0; opb = $signed({31'd0, recip(kden)}); sh = 6'd32; end
      endcase
    end else begin
      case (step_i)
        2'd0: begin opa = diag_q[0]; opb = half_i ? 64'(cy_q) : 64'(cx_q); sh = 6'd30; end
        2'd1: begin opa = diag_q[1]; opb = half_i ? 64'(cx_q) : 64'(cy_q); sh = 6'd30; end
        default: begin
          opa = 48'sd0;
          opb = $signed({31'd0, recip({2'b00, m_i, 1'b0})});
          sh = 6'd32;
        end
      endcase
    end
  end

  logic signed [63:0] a64;
  always_comb begin
    a64 = (step_i == 2'd2) ? 64'(acc_q) : 64'(opa);
    ma = a64[63] ? 64'(-a64) : 64'(a64);
    mb = opb[63] ? 64'(-opb) : 64'(opb);
    neg = a64[63] ^ opb[63];
    pa = ph_q[0] ? ma[63:32] : ma[31:0];
    pb = ph_q[1] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    case (ph_q)
      3'd0: prod_d = 128'(pp);
      3'd1: prod_d = prod_q + (128'(pp) << 32);
      3'd2: prod_d = prod_q + (128'(pp) << 32);
      3'd3: prod_d = prod_q + (128'(pp) << 64);
      default: prod_d = prod_q;
    endcase
    rnd = (prod_q + (128'd1 << (sh - 6'd1))) >> sh;
    term = neg ? -$signed({1'b0, rnd[65:0]}) : $signed({1'b0, rnd[65:0]});
  end

  assign done_o = go_i && (ph_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
      prod_q <= '0;
    end else if (go_i) begin
      if (ph_q == 3'd4) begin
        ph_q <= '0;
      end else begin
        ph_q <= ph_q + 3'd1;
        prod_q <= prod_d;
      end
    end
  end

  function automatic logic signed [47:0] sat(input logic signed [66:0] v);
    if (v > 67'(ValMax)) sat = ValMax;
    else if (v < 67'(ValMin)) sat = ValMin;
    else sat = v[47:0];
  endfunction

  logic [31:0] axm, aym, azm;
  logic [63:0] sqx, sqy, sqz;
  logic [65:0] ssum, sround;
  always_comb begin
    axm = point_i.coord_x[31] ? 32'(-point_i.coord_x) : 32'(point_i.coord_x);
    aym = point_i.coord_y[31] ? 32'(-point_i.coord_y) : 32'(point_i.coord_y);
    azm = point_i.coord_z[31] ? 32'(-point_i.coord_z) : 32'(point_i.coord_z);
    sqx = axm * axm;
    sqy = aym * aym;
    sqz = azm * azm;
    ssum = 66'(sqx) + 66'(sqy) + 66'(sqz);
    sround = (ssum + 66'd8192) >> 14;
  end

  logic signed [66:0] lres;
  always_comb begin
    if (kind_i == 1'b0) lres = 67'(acc_q) * 67'($signed({1'b0, coef}));
    else lres = 67'(acc_q);
  end

  assign result_o = (kind_i == 1'b0) ? prev_q[half_i] : diag_q[half_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsq_q <= '0;
      acc_q <= '0;
      diag_q[0] <= '0; diag_q[1] <= '0;
      prev_q[0] <= '0; prev_q[1] <= '0;
      prev2_q[0] <= '0; prev2_q[1] <= '0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
    end else begin
      if (start_i) begin
        cx_q <= point_i.coord_x; cy_q <= point_i.coord_y; cz_q <= point_i.coord_z;
        rsq_q <= (|sround[65:48]) ? 48'hFFFF_FFFF_FFFF : sround[47:0];
        prev_q[0] <= OneQ46; prev_q[1] <= '0;
        prev2_q[0] <= '0; prev2_q[1] <= '0;
        diag_q[0] <= OneQ46; diag_q[1] <= '0;
      end else if (col_init_i) begin
        prev_q[0] <= diag_q[0]; prev_q[1] <= diag_q[1];
        prev2_q[0] <= '0; prev2_q[1] <= '0;
      end else if (done_o) begin
        case (step_i)
          2'd0: acc_q <= 53'(term);
          2'd1: begin
            if (kind_i == 1'b0) acc_q <= 53'(lres - term);
            else if (half_i == 1'b0) acc_q <= 53'(67'(acc_q) - term);
            else acc_q <= 53'(67'(acc_q) + term);
          end
          default: begin
            if (kind_i == 1'b0) begin
              prev2_q[half_i] <= prev_q[half_i];
              prev_q[half_i] <= sat(term);
            end else if (half_i == 1'b0) begin
              // hold new N+ until N- is done with the old diagonal
              prev_q[0] <= sat(-term);
            end else begin
              diag_q[0] <= prev_q[0];
              diag_q[1] <= sat(-term);
            end
          end
        endcase
      end
      if (diag_init_i) begin
        diag_q[0] <= OneQ46; diag_q[1] <= '0;
      end
    end
  end

endmodule

FILE: rtl/shr_ctrl.sv
// controller: sequences l and m, the three multiply steps and output transfers
module shr_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  max_deg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        mul_done_i,
  output logic [2:0]  l_o,
  output logic [2:0]  m_o,
  output logic [1:0]  step_o,
  output logic        go_o,
  output logic        kind_o,
  output logic        half_o,
  output logic        start_o,
  output logic        col_init_o,
  output logic        diag_init_o,
  output logic signed [3:0] order_o,
  output logic        last_o
);
  import shr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_EMIT, S_NEXT, S_INIT} state_e;
  state_e state_q;
  logic [2:0] l_q, m_q, lmax_q;
  logic [1:0] step_q;
  logic       half_q, kind_q, zero_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign start_o     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_EMIT);
  assign go_o        = (state_q == S_CALC);
  assign col_init_o  = (state_q == S_INIT);
  assign diag_init_o = 1'b0;
  assign l_o = l_q; assign m_o = m_q; assign step_o = step_q;
  assign kind_o = kind_q; assign half_o = half_q;
  assign order_o = half_q ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
  assign last_o = (l_q == lmax_q) && (m_q == lmax_q) && (half_q || lmax_q == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q <= '0; m_q <= '0; step_q <= '0; lmax_q <= '0;
      half_q <= 1'b0; kind_q <= 1'b0; zero_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          lmax_q <= max_deg_i;
          l_q <= '0; m_q <= '0; half_q <= 1'b0; kind_q <= 1'b0;
          step_q <= '0;
          state_q <= S_EMIT;
        end
        S_CALC: if (mul_done_i) begin
          if (step_q == 2'd2) begin
            step_q <= '0;
            if (kind_q && !half_q) half_q <= 1'b1;
            else if (kind_q) begin half_q <= 1'b0; state_q <= S_EMIT; end
            else if (m_q != 3'd0 && !half_q) half_q <= 1'b1;
            else begin half_q <= 1'b0; state_q <= S_EMIT; end
          end else step_q <= step_q + 2'd1;
        end
        S_EMIT: if (out_ready_i) begin
          if (m_q != 3'd0 && !half_q) half_q <= 1'b1;
          else begin
            half_q <= 1'b0;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (l_q == lmax_q && m_q == lmax_q) begin
            state_q <= S_IDLE;
          end else if (l_q == lmax_q) begin
            m_q <= m_q + 3'd1; l_q <= m_q + 3'd1; kind_q <= 1'b1;
            state_q <= S_CALC;
          end else if (kind_q) begin
            kind_q <= 1'b0; state_q <= S_INIT;
          end else begin
            l_q <= l_q + 3'd1; state_q <= S_CALC;
          end
        end
        S_INIT: begin
          l_q <= l_q + 3'd1; state_q <= S_CALC;
        end
        default: state_q <= S_IDLE;
      endcase
      zero_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_q && out_valid_o) $error("unexpected state");
  end

  property p_emit_hold;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o && !out_ready_i |=> out_valid_o;
  endproperty
  a_emit_hold: assert property (p_emit_hold) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !start_o) else $error("accepted while busy");
  a_m_le_l: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> m_q <= l_q) else $error("order above degree");

endmodule

FILE: rtl/solid_harmonics_recurrence.sv
// top level: solid harmonics recurrence with apb configuration port
// the degree zero value is offered in the cycle after the point transfer
// each multiply runs on the shared 32x32 multiplier as four partial products and
// a rounding step; a value needs three multiplies, plus a transfer and a sequencing state
// one point at a time; a new point is accepted only in the idle state
// reset: max_degree is MAX_DEGREE_BOUND (7 by default), all other state registers clear
module solid_harmonics_recurrence #(
  parameter int unsigned MAX_DEGREE_BOUND = shr_pkg::MaxDegreeBound
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  shr_pkg::shr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output shr_pkg::shr_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import shr_pkg::*;

  logic [2:0] max_deg_q;
  logic [2:0] l, m;
  logic [1:0] step;
  logic go, kind, half, start, col_init, diag_init, last, mul_done;
  logic signed [3:0] order;
  logic signed [47:0] result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrMaxDegree) ? {29'd0, max_deg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_deg_q <= 3'(MAX_DEGREE_BOUND);
    end else if (psel && penable && pwrite && paddr[2] == AddrMaxDegree) begin
      max_deg_q <= (pwdata[2:0] > 3'(MAX_DEGREE_BOUND)) ? 3'(MAX_DEGREE_BOUND) : pwdata[2:0];
    end
  end

  shr_ctrl u_ctrl (
    .clk_i, .rst_ni, .max_deg_i(max_deg_q), .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .mul_done_i(mul_done), .l_o(l), .m_o(m),
    .step_o(step), .go_o(go),
    .kind_o(kind), .half_o(half), .start_o(start), .col_init_o(col_init),
    .diag_init_o(diag_init), .order_o(order), .last_o(last)
  );

  shr_datapath u_dp (
    .clk_i, .rst_ni, .point_i(in_data_i), .l_i(l), .m_i(m), .step_i(step),
    .go_i(go), .kind_i(kind), .half_i(half), .start_i(start),
    .col_init_i(col_init), .diag_init_i(diag_init), .done_o(mul_done),
    .result_o(result)
  );

  assign out_data_o.degree = l;
  assign out_data_o.order  = order;
  assign out_data_o.value  = result;
  assign out_data_o.last   = last;

endmodule

FILE: dv/solid_harmonics_recurrence_tb.sv
// testbench for the solid harmonics recurrence: predicts every harmonic and checks each transfer
module solid_harmonics_recurrence_tb;
  import shr_pkg::*;

  typedef logic signed [63:0] s64_t;

  class harmonic_scoreboard;
    shr_out_t pending[$];
    int unsigned err_cnt;
    int unsigned point_cnt;
    int unsigned value_cnt;
    logic [2:0] degree_cfg;
    s64_t cx, cy, cz;
    logic [63:0] rsq;

    function new();
      err_cnt = 0;
      point_cnt = 0;
      value_cnt = 0;
      degree_cfg = 3'd7;
    endfunction

    function automatic logic [63:0] mag(s64_t v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // exact product, rounded half away from zero
    function automatic s64_t rmul(s64_t a, s64_t b, int s);
      logic [127:0] p;
      logic [63:0] q;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = p + (128'd1 << (s - 1));
      q = 64'(p >> s);
      return ((a < 0) != (b < 0)) ? -s64_t'(q) : s64_t'(q);
    endfunction

    function automatic s64_t sat(s64_t v);
      if (v > s64_t'(ValMax)) return s64_t'(ValMax);
      if (v < s64_t'(ValMin)) return s64_t'(ValMin);
      return v;
    endfunction

    function automatic s64_t inv(int unsigned k);
      if (k == 0) return 0;
      return s64_t'(((64'd1 << 32) + k / 2) / k);
    endfunction

    function automatic s64_t lstep(int unsigned l, int unsigned m, s64_t n1, s64_t n2);
      s64_t t;
      t = s64_t'(2 * l - 1) * rmul(cz, n1, 30) - rmul(s64_t'(rsq), n2, 46);
      return sat(rmul(t, inv((l + m) * (l - m)), 32));
    endfunction

    function automatic void push(int unsigned l, int m, s64_t v);
      shr_out_t r;
      r.degree = 3'(l);
      r.order = 4'(m);
      r.value = v[47:0];
      r.last = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    function automatic void note_point(shr_in_t p);
      int unsigned lmax;
      s64_t prev[2], prev2[2], diag[2], v, up, um, r;
      logic [63:0] sq;
      lmax = degree_cfg > MaxDegreeBound ? MaxDegreeBound : degree_cfg;
      cx = s64_t'(p.coord_x);
      cy = s64_t'(p.coord_y);
      cz = s64_t'(p.coord_z);
      sq = mag(cx) * mag(cx) + mag(cy) * mag(cy) + mag(cz) * mag(cz);
      sq = (sq + (64'd1 << 13)) >> 14;
      rsq = sq > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : sq;
      point_cnt++;
      prev[0] = s64_t'(OneQ46);
      prev2[0] = 0;
      push(0, 0, prev[0]);
      for (int unsigned l = 1; l <= lmax; l++) begin
        v = lstep(l, 0, prev[0], prev2[0]);
        prev2[0] = prev[0];
        prev[0] = v;
        push(l, 0, v);
      end
      diag[0] = s64_t'(OneQ46);
      diag[1] = 0;
      for (int unsigned m = 1; m <= lmax; m++) begin
        r = inv(2 * m);
        up = rmul(cx, diag[0], 30) - rmul(cy, diag[1], 30);
        um = rmul(cy, diag[0], 30) + rmul(cx, diag[1], 30);
        diag[0] = sat(-rmul(up, r, 32));
        diag[1] = sat(-rmul(um, r, 32));
        push(m, m, diag[0]);
        push(m, -m, diag[1]);
        prev = diag;
        prev2[0] = 0;
        prev2[1] = 0;
        for (int unsigned l = m + 1; l <= lmax; l++) begin
          for (int i = 0; i < 2; i++) begin
            v = lstep(l, m, prev[i], prev2[i]);
            prev2[i] = prev[i];
            prev[i] = v;
          end
          push(l, m, prev[0]);
          push(l, -m, prev[1]);
        end
      end
      pending[$].last = 1'b1;
    endfunction

    function automatic void check_value(shr_out_t got);
      shr_out_t want;
      value_cnt++;
      if (pending.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h", $time, got);
        err_cnt++;
        return;
      end
      want = pending.pop_front();
      if (got.degree !== want.degree) begin
        $display("%0t degree: expected %0d, actual %0d", $time, want.degree, got.degree);
        err_cnt++;
      end
      if (got.order !== want.order) begin
        $display("%0t order: expected %0d, actual %0d", $time, want.order, got.order);
        err_cnt++;
      end
      if (got.value !== want.value) begin
        $display("%0t value l=%0d m=%0d: expected %h, actual %h", $time,
                 want.degree, want.order, want.value, got.value);
        err_cnt++;
      end
      if (got.last !== want.last) begin
        $display("%0t last: expected %b, actual %b", $time, want.last, got.last);
        err_cnt++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  shr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  shr_out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit calm = 1'b0;
  harmonic_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  solid_harmonics_recurrence u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // sink side with random stall bursts
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_value(out_data_o);
    end
  end

  task automatic write_degree(logic [2:0] deg);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {AddrMaxDegree, 2'b00};
    pwdata <= {29'd0, deg};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.degree_cfg = deg;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{coord_x: x, coord_y: y, coord_z: z};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_point(in_data_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh4000_0000;
      1: return -32'sh4000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  localparam logic signed [31:0] One = 32'sh4000_0000;

  initial begin
    logic [2:0] deg;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // directed points at reset degree
    send_point(0, 0, 0);
    send_point(One, 0, 0);
    send_point(0, One, 0);
    send_point(0, 0, One);
    send_point(-One, -One, -One);
    send_point(One, One, One);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001);
    send_point(32'shFFFF_FFFF, 32'sh2000_0000, -32'sh2000_0000);
    drain();
    write_degree(3'd0);
    send_point(One, One, One);
    send_point(32'sh1234_5678, -32'sh0765_4321, 32'sh3000_0000);
    drain();
    write_degree(3'd1);
    send_point(One, -One, 32'sh2000_0000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      deg = (ph == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      write_degree(deg);
      if (ph == 7) calm = 1'b1;
      for (int n = 0; n < 33; n++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    write_degree(3'd7);
    for (int n = 0; n < 10; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    $display("covered %0d points and %0d harmonic values over degrees 0 to 7",
             sb.point_cnt, sb.value_cnt);
    if (sb.err_cnt == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
